### hw/rtl/cfpd_pkg.sv
package cfpd_pkg;

  localparam int unsigned FIELD_DIGITS_DEF = 3;
  localparam int unsigned NAME_LIMIT_DEF   = 99;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned VALUE_W = 10;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned TDATA_W = 40;

  localparam logic [BYTE_W-1:0]  COLON   = 8'h3a;
  localparam logic [BYTE_W-1:0]  DIGIT_0 = 8'h30;
  localparam logic [BYTE_W-1:0]  DIGIT_9 = 8'h39;
  localparam logic [VALUE_W-1:0] ACC_MAX = 10'd1023;

  typedef enum logic [KIND_W-1:0] {
    KIND_HEADER   = 3'd0,
    KIND_NAME     = 3'd1,
    KIND_NAME_END = 3'd2,
    KIND_DATA     = 3'd3,
    KIND_ERROR    = 3'd4
  } kind_e;

  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_TOTAL  = 6'b000010,
    PH_NUMBER = 6'b000100,
    PH_SIZE   = 6'b001000,
    PH_NAME   = 6'b010000,
    PH_DATA   = 6'b100000
  } phase_e;

  typedef struct packed {
    logic               last;
    logic               final_fragment;
    logic               accepted;
    logic [BYTE_W-1:0]  byte_value;
    logic [VALUE_W-1:0] data_size;
    logic [VALUE_W-1:0] fragment_number;
    logic [VALUE_W-1:0] total_fragments;
    kind_e              kind;
  } result_t;

endpackage

### hw/rtl/cfpd_parser.sv
module cfpd_parser #(
  parameter int unsigned FIELD_DIGITS = cfpd_pkg::FIELD_DIGITS_DEF,
  parameter int unsigned NAME_LIMIT   = cfpd_pkg::NAME_LIMIT_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [cfpd_pkg::BYTE_W-1:0] byte_i,
  input  logic                        first_i,
  output logic                        res_valid_o,
  output cfpd_pkg::result_t           res_o
);

  localparam int unsigned DW = $clog2(FIELD_DIGITS + 1);
  localparam int unsigned NW = $clog2(NAME_LIMIT + 1);
  localparam int unsigned VW = cfpd_pkg::VALUE_W;
  localparam int unsigned MW = VW + 4;

  cfpd_pkg::phase_e phase_q, phase_d, ph;
  logic [VW-1:0] acc_q, acc_d, acc;
  logic [DW-1:0] dcnt_q, dcnt_d, dcnt;
  logic          nd_q, nd_d, nd;
  logic [VW-1:0] total_q, total_d, total_h;
  logic [VW-1:0] number_q, number_d, number_h;
  logic [VW-1:0] size_q, size_d, size_h;
  logic [NW-1:0] ncnt_q, ncnt_d, ncnt;
  logic [VW-1:0] rem_q, rem_d, rem;
  logic          is_colon, is_digit;
  logic [MW-1:0] acc_mul;
  logic [VW-1:0] acc_sat;
  logic [VW-1:0] rem_dec;

  assign is_colon = (byte_i == cfpd_pkg::COLON);
  assign is_digit = (byte_i >= cfpd_pkg::DIGIT_0) && (byte_i <= cfpd_pkg::DIGIT_9);

  // restart on first byte
  assign ph       = first_i ? cfpd_pkg::PH_TOTAL : phase_q;
  assign acc      = first_i ? '0 : acc_q;
  assign dcnt     = first_i ? '0 : dcnt_q;
  assign nd       = first_i ? 1'b0 : nd_q;
  assign total_h  = first_i ? '0 : total_q;
  assign number_h = first_i ? '0 : number_q;
  assign size_h   = first_i ? '0 : size_q;
  assign ncnt     = first_i ? '0 : ncnt_q;
  assign rem      = first_i ? '0 : rem_q;

  // acc * 10 + digit, saturating
  assign acc_mul = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0}
                 + MW'(byte_i - cfpd_pkg::DIGIT_0);
  assign acc_sat = (acc_mul > MW'(cfpd_pkg::ACC_MAX)) ? cfpd_pkg::ACC_MAX : acc_mul[VW-1:0];
  assign rem_dec = (rem != '0) ? rem - VW'(1) : rem;

  always_comb begin
    phase_d     = ph;
    acc_d       = acc;
    dcnt_d      = dcnt;
    nd_d        = nd;
    total_d     = total_h;
    number_d    = number_h;
    size_d      = size_h;
    ncnt_d      = ncnt;
    rem_d       = rem;
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.kind  = cfpd_pkg::KIND_HEADER;
    unique case (ph) inside
      cfpd_pkg::PH_TOTAL, cfpd_pkg::PH_NUMBER, cfpd_pkg::PH_SIZE: begin
        if (is_colon) begin
          acc_d  = '0;
          dcnt_d = '0;
          nd_d   = 1'b0;
          if (ph == cfpd_pkg::PH_TOTAL) begin
            total_d = acc;
            phase_d = cfpd_pkg::PH_NUMBER;
          end else if (ph == cfpd_pkg::PH_NUMBER) begin
            number_d = acc;
            phase_d  = cfpd_pkg::PH_SIZE;
          end else begin
            size_d                = acc;
            phase_d               = cfpd_pkg::PH_NAME;
            ncnt_d                = '0;
            res_valid_o           = 1'b1;
            res_o.kind            = cfpd_pkg::KIND_HEADER;
            res_o.total_fragments = total_h;
            res_o.fragment_number = number_h;
            res_o.data_size       = acc;
            res_o.accepted        = (total_h != '0);
            res_o.final_fragment  = (number_h == total_h);
          end
        end else if (dcnt >= DW'(FIELD_DIGITS)) begin
          res_valid_o = 1'b1;
          res_o.kind  = cfpd_pkg::KIND_ERROR;
          phase_d     = cfpd_pkg::PH_IDLE;
          acc_d       = '0;
          dcnt_d      = '0;
          nd_d        = 1'b0;
        end else begin
          dcnt_d = dcnt + DW'(1);
          if (!nd && is_digit) begin
            acc_d = acc_sat;
          end else begin
            nd_d = 1'b1;
          end
        end
      end
      cfpd_pkg::PH_NAME: begin
        res_valid_o = 1'b1;
        if (is_colon) begin
          res_o.kind = cfpd_pkg::KIND_NAME_END;
          if (size_h == '0) begin
            res_o.last = 1'b1;
            phase_d    = cfpd_pkg::PH_IDLE;
          end else begin
            rem_d   = size_h;
            phase_d = cfpd_pkg::PH_DATA;
          end
        end else if (ncnt >= NW'(NAME_LIMIT)) begin
          res_o.kind = cfpd_pkg::KIND_ERROR;
          phase_d    = cfpd_pkg::PH_IDLE;
          acc_d      = '0;
          dcnt_d     = '0;
          nd_d       = 1'b0;
        end else begin
          ncnt_d           = ncnt + NW'(1);
          res_o.kind       = cfpd_pkg::KIND_NAME;
          res_o.byte_value = byte_i;
        end
      end
      cfpd_pkg::PH_DATA: begin
        res_valid_o      = 1'b1;
        res_o.kind       = cfpd_pkg::KIND_DATA;
        res_o.byte_value = byte_i;
        rem_d            = rem_dec;
        if (rem_dec == '0) begin
          res_o.last = 1'b1;
          phase_d    = cfpd_pkg::PH_IDLE;
        end
      end
      default: begin
        phase_d = cfpd_pkg::PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= cfpd_pkg::PH_IDLE;
      acc_q    <= '0;
      dcnt_q   <= '0;
      nd_q     <= 1'b0;
      total_q  <= '0;
      number_q <= '0;
      size_q   <= '0;
      ncnt_q   <= '0;
      rem_q    <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      acc_q    <= acc_d;
      dcnt_q   <= dcnt_d;
      nd_q     <= nd_d;
      total_q  <= total_d;
      number_q <= number_d;
      size_q   <= size_d;
      ncnt_q   <= ncnt_d;
      rem_q    <= rem_d;
    end
  end

`ifndef SYNTHESIS
  a_data_rem_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == cfpd_pkg::PH_DATA |-> rem_q != '0)
    else $error("data phase with nothing left to pass");

  a_error_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_valid_o && res_o.kind == cfpd_pkg::KIND_ERROR
    |=> phase_q == cfpd_pkg::PH_IDLE && acc_q == '0 && dcnt_q == '0)
    else $error("error did not return parser to idle");

  a_name_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ncnt_q <= NW'(NAME_LIMIT) && dcnt_q <= DW'(FIELD_DIGITS))
    else $error("name or digit count beyond limit");

  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last
    |-> res_o.kind == cfpd_pkg::KIND_DATA || res_o.kind == cfpd_pkg::KIND_NAME_END)
    else $error("last set on a word that cannot end a packet");
`endif

endmodule

### hw/rtl/colon_field_packet_deframer.sv
// Colon-field packet deframer. Bytes of a datagram enter on the slave stream,
// tuser high on the first byte of each datagram (that byte restarts parsing and
// is the first character of the total field). The three decimal fields
// total:number:size: produce one header word; then every name byte comes out,
// a name-end word at the closing colon, and exactly size data bytes, the last
// one with tlast (or the name end, when size is zero). An over-long field or
// name gives one error word and the block ignores bytes until the next first
// byte. Throughput is one byte per cycle while the master side takes results:
// a byte passes an input register, the parser logic and an output register,
// and moves on from the input register only when the output register is free,
// and both sides may stall at any time.
module colon_field_packet_deframer #(
  parameter int unsigned FIELD_DIGITS = cfpd_pkg::FIELD_DIGITS_DEF,
  parameter int unsigned NAME_LIMIT   = cfpd_pkg::NAME_LIMIT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [cfpd_pkg::BYTE_W-1:0]   s_axis_tdata_i,  // byte_in
  input  logic                          s_axis_tuser_i,  // first_byte
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // total_fragments, fragment_number, data_size, byte_value, accepted, final_fragment
  output logic [cfpd_pkg::TDATA_W-1:0]  m_axis_tdata_o,
  output logic [cfpd_pkg::KIND_W-1:0]   m_axis_tuser_o,  // item_kind
  output logic                          m_axis_tlast_o   // last_of_packet
);

  logic                        in_valid_q, in_valid_d;
  logic [cfpd_pkg::BYTE_W-1:0] in_byte_q;
  logic                        in_first_q;
  logic                        out_valid_q, out_valid_d;
  cfpd_pkg::result_t           out_res_q;
  logic                        out_free, step, s_fire;
  logic                        res_valid;
  cfpd_pkg::result_t           res;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign step            = in_valid_q && out_free;
  assign s_axis_tready_o = !in_valid_q || out_free;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  cfpd_parser #(
    .FIELD_DIGITS(FIELD_DIGITS),
    .NAME_LIMIT  (NAME_LIMIT)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .byte_i     (in_byte_q),
    .first_i    (in_first_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_fire) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = res_valid;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_byte_q  <= s_axis_tdata_i;
      in_first_q <= s_axis_tuser_i;
    end
    if (step && res_valid) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_res_q.final_fragment, out_res_q.accepted,
                            out_res_q.byte_value, out_res_q.data_size,
                            out_res_q.fragment_number, out_res_q.total_fragments};
  assign m_axis_tuser_o  = out_res_q.kind;
  assign m_axis_tlast_o  = out_res_q.last;

endmodule
